@@ design/page_map_table_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// Page map table engine assertion macros
// Concurrent checks sampled on clk and masked during rst.
// ----------------------------------------------------------------------------
`ifndef PAGE_MAP_TABLE_ENGINE_TOP_DEFINES_SVH
`define PAGE_MAP_TABLE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define PMTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pmte_pkg.sv @@
// ----------------------------------------------------------------------------
// Page map table engine package
// Field widths, opcodes, status codes and word types shared by the engine.
// ----------------------------------------------------------------------------
package pmte_pkg;

  localparam int PAGE_W    = 12;
  localparam int CFG_W     = 13;
  localparam int COUNT_W   = 7;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int BLK_IDX_W = 6;

  localparam int MAP_DEPTH_DEF       = 4096;
  localparam int PAGES_PER_BLOCK_DEF = 64;

  localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = CFG_W'(4096);

  localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESET  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [PAGE_W-1:0]    logical_page;
    logic [PAGE_W-1:0]    physical_page;
    logic [BLK_IDX_W-1:0] block_index;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                mapped;
    logic [PAGE_W-1:0]   mapped_page;
    logic [COUNT_W-1:0]  invalid_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
  } split_ctl_t;

endpackage

@@ design/pmte_ram.sv @@
// ----------------------------------------------------------------------------
// Page map table engine RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module pmte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pmte_split.sv @@
// ----------------------------------------------------------------------------
// Page map table engine page splitter
// Splits a page into block and offset by reciprocal multiply, two stages.
// ----------------------------------------------------------------------------
module pmte_split import pmte_pkg::*; #(
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF,
  parameter int BLK_W = 6,
  localparam int OFF_W = $clog2(PAGES_PER_BLOCK)
) (
  input  logic              clk,
  input  split_ctl_t        ctl,
  input  logic [PAGE_W-1:0] page,
  output logic [BLK_W-1:0]  block,
  output logic [OFF_W-1:0]  offset
);

  localparam int SHIFT  = PAGE_W + $clog2(PAGES_PER_BLOCK);
  localparam int MUL_W  = PAGE_W + 2;
  localparam int PROD_W = PAGE_W + MUL_W;
  localparam logic [MUL_W-1:0] MUL_K =
    MUL_W'(((64'd1 << SHIFT) + 64'(PAGES_PER_BLOCK) - 64'd1) / 64'(PAGES_PER_BLOCK));
  localparam logic [PAGE_W-1:0] PPB_K = PAGE_W'(PAGES_PER_BLOCK);

  logic [PROD_W-1:0] prod;
  logic [PAGE_W-1:0] quot;
  logic [PAGE_W-1:0] page_d;
  logic [PAGE_W-1:0] base;

  assign prod = PROD_W'(page) * PROD_W'(MUL_K);
  assign base = PAGE_W'(quot * PPB_K);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quot   <= PAGE_W'(prod >> SHIFT);
      page_d <= page;
    end
    if (ctl.step) begin
      offset <= OFF_W'(page_d - base);
    end
  end

  assign block = BLK_W'(quot);

endmodule

@@ design/page_map_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// Page map table engine
// Each command steps through accept, forward map read, block split, row write.
// The result word is registered in the row write step; the next command can be
// taken in the cycle after. A result word not yet taken holds the row write and the accept.
// After rst a clearing pass over min(MAP_DEPTH, 4096) entries runs, commands wait.
// ----------------------------------------------------------------------------
`include "page_map_table_engine_top_defines.svh"

module page_map_table_engine_top import pmte_pkg::*; #(
  parameter int MAP_DEPTH       = MAP_DEPTH_DEF,
  parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int PAGE_SPAN   = 1 << PAGE_W;
  localparam int ENTRIES     = (MAP_DEPTH < PAGE_SPAN) ? MAP_DEPTH : PAGE_SPAN;
  localparam int NUM_BLOCKS  = (MAP_DEPTH + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;
  localparam int PAGE_BLOCKS = (ENTRIES + PAGES_PER_BLOCK - 1) / PAGES_PER_BLOCK;
  localparam int IDX_SPAN    = 1 << BLK_IDX_W;
  localparam int RST_BLOCKS  = (NUM_BLOCKS < IDX_SPAN) ? NUM_BLOCKS : IDX_SPAN;
  localparam int BLK_DEPTH   = (PAGE_BLOCKS > RST_BLOCKS) ? PAGE_BLOCKS : RST_BLOCKS;
  localparam int AW          = $clog2(ENTRIES);
  localparam int BLK_W       = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int OFF_W       = $clog2(PAGES_PER_BLOCK);
  localparam int ROW_W       = PAGES_PER_BLOCK + COUNT_W;
  localparam int MAP_W       = PAGE_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FWD   = 5'b00100,
    S_SPLIT = 5'b01000,
    S_WB    = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] pages_in_use;
  logic [AW-1:0]    clr_addr;
  cmd_t             cmd_q;
  logic             err_q;
  logic             old_valid;
  logic [PAGE_W-1:0] old_page;

  logic err_in, lp_ok, pp_ok, blk_ok;
  logic accept, clearing, wb_go;
  logic is_update, is_reset;

  logic             fwd_we, fwd_re;
  logic [AW-1:0]    fwd_waddr;
  logic [MAP_W-1:0] fwd_wdata, fwd_rdata;
  logic             rev_we, poison;
  logic [AW-1:0]    rev_waddr;
  logic [MAP_W-1:0] rev_wdata;
  logic             blk_we, blk_re, row_we;
  logic [BLK_W-1:0] blk_waddr, blk_raddr;
  logic [ROW_W-1:0] blk_wdata, blk_rdata, row_next;

  split_ctl_t         split_ctl;
  logic [PAGE_W-1:0]  split_page;
  logic [BLK_W-1:0]   split_block;
  logic [OFF_W-1:0]   split_off;
  logic [BLK_W-1:0]   row_blk;

  logic [PAGES_PER_BLOCK-1:0] row_bits;
  logic [COUNT_W-1:0]         row_cnt, cnt_inc;
  logic                       bit_set;
  rsp_t                       rsp_next;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign clearing  = (state == S_CLEAR);
  assign wb_go     = (state == S_WB) && (!rsp_valid || rsp_ready);

  assign is_update = (cmd_q.opcode == OP_UPDATE);
  assign is_reset  = (cmd_q.opcode == OP_RESET);

  assign lp_ok  = ({1'b0, cmd.logical_page} < pages_in_use) &&
                  (32'(cmd.logical_page) < MAP_DEPTH);
  assign pp_ok  = ({1'b0, cmd.physical_page} < pages_in_use) &&
                  (32'(cmd.physical_page) < MAP_DEPTH);
  assign blk_ok = (32'(cmd.block_index) < NUM_BLOCKS);

  always_comb begin
    unique case (cmd.opcode)
      OP_UPDATE: err_in = !(lp_ok && pp_ok);
      OP_LOOKUP: err_in = !lp_ok;
      OP_RESET:  err_in = !blk_ok;
      default:   err_in = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == AW'(ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE:  if (cmd_valid) state_next = S_FWD;
      S_FWD:   state_next = S_SPLIT;
      S_SPLIT: state_next = S_WB;
      S_WB:    if (wb_go) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pages_in_use <= PAGES_IN_USE_RST;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_valid) begin
        pages_in_use <= cfg_data;
      end
      if (wb_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      err_q <= err_in;
    end
    if (state == S_FWD) begin
      old_valid <= fwd_rdata[PAGE_W];
      old_page  <= fwd_rdata[PAGE_W-1:0];
    end
    if (wb_go) begin
      rsp <= rsp_next;
    end
  end

  // forward map
  assign fwd_re    = accept;
  assign fwd_we    = clearing || (wb_go && is_update && !err_q);
  assign fwd_waddr = clearing ? clr_addr : AW'(cmd_q.logical_page);
  assign fwd_wdata = clearing ? '0 : {1'b1, cmd_q.physical_page};

  // reverse map: poison the old page, then bind the new one
  assign poison    = (state == S_SPLIT) && is_update && !err_q && old_valid;
  assign rev_we    = clearing || poison || (wb_go && is_update && !err_q);
  assign rev_waddr = clearing ? clr_addr :
                     poison   ? AW'(old_page) : AW'(cmd_q.physical_page);
  assign rev_wdata = (clearing || poison) ? '0 : {1'b1, cmd_q.logical_page};

  // block split of the page of interest
  assign split_ctl.load = (state == S_FWD);
  assign split_ctl.step = (state == S_SPLIT);
  assign split_page     = (is_update && !fwd_rdata[PAGE_W]) ? cmd_q.physical_page
                                                            : fwd_rdata[PAGE_W-1:0];

  // block rows: invalid bitmap plus count
  assign row_blk   = is_reset ? BLK_W'(cmd_q.block_index) : split_block;
  assign blk_re    = (state == S_SPLIT);
  assign blk_raddr = row_blk;
  assign blk_we    = (clearing && (32'(clr_addr) < BLK_DEPTH)) || (wb_go && row_we);
  assign blk_waddr = clearing ? BLK_W'(clr_addr) : row_blk;
  assign blk_wdata = clearing ? '0 : row_next;

  assign row_bits = blk_rdata[ROW_W-1:COUNT_W];
  assign row_cnt  = blk_rdata[COUNT_W-1:0];
  assign bit_set  = row_bits[split_off];
  assign cnt_inc  = (row_cnt == '1) ? row_cnt : row_cnt + COUNT_W'(1);

  always_comb begin
    rsp_next = '0;
    row_we   = 1'b0;
    row_next = '0;
    if (err_q) begin
      rsp_next.status = ST_RANGE;
    end else if (is_reset) begin
      row_we = 1'b1;
    end else if (old_valid) begin
      rsp_next.mapped      = 1'b1;
      rsp_next.mapped_page = old_page;
      rsp_next.invalid_count = row_cnt;
      if (is_update) begin
        if (bit_set) begin
          rsp_next.status = ST_INVALID;
        end else begin
          row_we   = 1'b1;
          row_next = {row_bits | (PAGES_PER_BLOCK'(1) << split_off), cnt_inc};
          rsp_next.invalid_count = cnt_inc;
        end
      end
    end else if (is_update) begin
      rsp_next.invalid_count = row_cnt;
    end
  end

  pmte_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ENTRIES)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .re    (fwd_re),
    .raddr (AW'(cmd.logical_page)),
    .rdata (fwd_rdata)
  );

  pmte_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ENTRIES)
  ) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (rev_waddr),
    .wdata (rev_wdata),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  pmte_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BLK_DEPTH)
  ) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  pmte_split #(
    .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
    .BLK_W           (BLK_W)
  ) u_split (
    .clk    (clk),
    .ctl    (split_ctl),
    .page   (split_page),
    .block  (split_block),
    .offset (split_off)
  );

  `PMTE_ASSERT_NEXT(a_accept_reads_fwd, cmd_valid && cmd_ready, state == S_FWD, "accept did not start read")
  `PMTE_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !fwd_we && !blk_we && !rev_we, "write while idle")
  `PMTE_ASSERT_NOW(a_err_no_write, state == S_WB && err_q, !fwd_we && !blk_we && !rev_we, "write on error")
  `PMTE_ASSERT_NOW(a_dbl_mapped, rsp_valid && rsp.status == ST_INVALID, rsp.mapped, "double invalid unmapped")

endmodule

@@ sim/page_map_table_engine_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page map table engine testbench
// Drives map update, lookup and block reset commands through the valid/ready
// command port and checks every response word against a software copy of the
// translation tables. A directed table covers the address and bound extremes,
// remapping, double invalidation and unknown opcodes. Random phases follow
// with different page bounds and sender/receiver idling.
// ----------------------------------------------------------------------------
module page_map_table_engine_top_tb;
  import pmte_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                  NUM_BLOCKS  = MAP_DEPTH_DEF / PAGES_PER_BLOCK_DEF;
  localparam int                  COUNT_LIMIT = 127;
  localparam int                  CYCLE_LIMIT = 400000;
  localparam int                  PHASE_ITEMS = 150;
  localparam int                  HOLD_CYCLES = 300;
  localparam int                  SEND_IDLE [4] = '{0, 71, 0, 38};
  localparam int                  RECV_STALL [4] = '{0, 0, 71, 38};
  localparam logic [CFG_W-1:0]    PHASE_BOUNDS [4] = '{13'd4096, 13'd200, 13'd4095, 13'd64};

  typedef struct packed {
    bit              valid;
    bit [PAGE_W-1:0] page;
  } page_link_t;

  typedef struct {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg_value;
    cmd_t             c;
    bit               known;
    rsp_t             expected;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_t             cmd = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;

  page_link_t       fwd_map [MAP_DEPTH_DEF];
  bit               invalid_bits [MAP_DEPTH_DEF];
  bit [COUNT_W-1:0] invalid_cnt [NUM_BLOCKS];
  logic [CFG_W-1:0] page_limit = PAGES_IN_USE_RST;

  rsp_t      translation_results [$];
  stim_row_t directed [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_kick      = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int commands_sent  = 0;
  int results_seen   = 0;
  int double_invals  = 0;
  int range_errors   = 0;
  int mapped_hits    = 0;

  page_map_table_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  function automatic bit page_in_range(logic [PAGE_W-1:0] p);
    return CFG_W'(p) < page_limit;
  endfunction

  function automatic rsp_t translate_command(cmd_t c);
    rsp_t       r;
    page_link_t old;
    int         blk;
    r = '0;
    case (c.opcode)
      OP_UPDATE: begin
        if (!page_in_range(c.logical_page) || !page_in_range(c.physical_page)) begin
          r.status = ST_RANGE;
        end else begin
          old = fwd_map[c.logical_page];
          if (old.valid) begin
            blk = old.page / PAGES_PER_BLOCK_DEF;
            r.mapped = 1'b1;
            r.mapped_page = old.page;
            if (invalid_bits[old.page]) begin
              r.status = ST_INVALID;
            end else begin
              invalid_bits[old.page] = 1'b1;
              if (invalid_cnt[blk] != COUNT_LIMIT) invalid_cnt[blk]++;
            end
            r.invalid_count = invalid_cnt[blk];
          end else begin
            r.invalid_count = invalid_cnt[c.physical_page / PAGES_PER_BLOCK_DEF];
          end
          fwd_map[c.logical_page] = '{1'b1, c.physical_page};
        end
      end
      OP_LOOKUP: begin
        if (!page_in_range(c.logical_page)) begin
          r.status = ST_RANGE;
        end else if (fwd_map[c.logical_page].valid) begin
          r.mapped = 1'b1;
          r.mapped_page = fwd_map[c.logical_page].page;
          r.invalid_count = invalid_cnt[r.mapped_page / PAGES_PER_BLOCK_DEF];
        end
      end
      OP_RESET: begin
        for (int i = 0; i < PAGES_PER_BLOCK_DEF; i++)
          invalid_bits[c.block_index * PAGES_PER_BLOCK_DEF + i] = 1'b0;
        invalid_cnt[c.block_index] = '0;
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t cmd_row(logic [OPCODE_W-1:0] op, int lp, int pp, int blk);
    stim_row_t row;
    row = '{default: '0};
    row.c = '{op, PAGE_W'(lp), PAGE_W'(pp), BLK_IDX_W'(blk)};
    return row;
  endfunction

  function automatic stim_row_t known_row(logic [OPCODE_W-1:0] op, int lp, int pp, int blk,
                                          logic [STATUS_W-1:0] st, bit m, int mp, int cnt);
    stim_row_t row;
    row = cmd_row(op, lp, pp, blk);
    row.known = 1'b1;
    row.expected = '{st, m, PAGE_W'(mp), COUNT_W'(cnt)};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(int value);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_value = CFG_W'(value);
    return row;
  endfunction

  // Mostly small windows so pages get remapped and invalidated repeatedly.
  function automatic logic [PAGE_W-1:0] pick_page(int window);
    int span;
    span = (page_limit != 0 && page_limit < window) ? int'(page_limit) : window;
    if ($urandom_range(99) < 85) return PAGE_W'($urandom_range(span - 1));
    return PAGE_W'($urandom);
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    pick = $urandom_range(99);
    c.logical_page = pick_page(32);
    c.physical_page = pick_page(256);
    c.block_index = ($urandom_range(3) == 0) ? BLK_IDX_W'($urandom)
                                             : BLK_IDX_W'($urandom_range(3));
    if (pick < 52) c.opcode = OP_UPDATE;
    else if (pick < 80) c.opcode = OP_LOOKUP;
    else if (pick < 88) c.opcode = OP_RESET;
    else if (pick < 92) c.opcode = OP_UNUSED;
    else c = cmd_t'($urandom);
    return c;
  endfunction

  task automatic send_command(cmd_t c, bit known, rsp_t typed);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    predicted = translate_command(c);
    translation_results.push_back(known ? typed : predicted);
    commands_sent++;
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    while (translation_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_page_limit(logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_limit = value;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Receiver: random stalls, plus a long hold when kicked.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (translation_results.size() == 0) begin
        mismatches++;
        $display("%0t: response word with nothing expected, got %0h", $time, rsp);
      end else begin
        want = translation_results.pop_front();
        compare_field("status", want.status, rsp.status);
        compare_field("mapped", want.mapped, rsp.mapped);
        compare_field("mapped_page", want.mapped_page, rsp.mapped_page);
        compare_field("invalid_count", want.invalid_count, rsp.invalid_count);
        if (want.status == ST_INVALID) double_invals++;
        if (want.status == ST_RANGE) range_errors++;
        if (want.mapped) mapped_hits++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, translation_results.size());
      $display("page_map_table_engine_top_tb failed");
      $finish;
    end
  end

  initial begin
    directed.push_back(known_row(OP_LOOKUP, 0, 0, 0, ST_OK, 0, 0, 0));
    directed.push_back(known_row(OP_LOOKUP, 4095, 0, 0, ST_OK, 0, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 0, 0, 0, ST_OK, 0, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 4095, 4095, 0, ST_OK, 0, 0, 0));
    directed.push_back(known_row(OP_LOOKUP, 0, 0, 0, ST_OK, 1, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 0, 1, 0, ST_OK, 1, 0, 1));
    directed.push_back(cmd_row(OP_UPDATE, 1, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 1, 2, 0, ST_INVALID, 1, 0, 1));
    directed.push_back(known_row(OP_LOOKUP, 4095, 0, 0, ST_OK, 1, 4095, 0));
    directed.push_back(known_row(OP_UPDATE, 4095, 64, 0, ST_OK, 1, 4095, 1));
    directed.push_back(known_row(OP_RESET, 0, 0, 0, ST_OK, 0, 0, 0));
    directed.push_back(cmd_row(OP_LOOKUP, 1, 0, 0));
    directed.push_back(known_row(OP_RESET, 0, 0, 63, ST_OK, 0, 0, 0));
    directed.push_back(known_row(OP_UNUSED, 4095, 4095, 63, ST_RANGE, 0, 0, 0));
    directed.push_back(cmd_row(OP_UPDATE, 'haaa, 'h555, 'h2a));
    directed.push_back(cmd_row(OP_UPDATE, 'h555, 'haaa, 'h15));
    directed.push_back(cfg_row(1));
    directed.push_back(known_row(OP_UPDATE, 0, 1, 0, ST_RANGE, 0, 0, 0));
    directed.push_back(known_row(OP_LOOKUP, 1, 0, 0, ST_RANGE, 0, 0, 0));
    directed.push_back(cmd_row(OP_LOOKUP, 0, 0, 0));
    directed.push_back(cmd_row(OP_UPDATE, 0, 0, 0));
    directed.push_back(cfg_row(0));
    directed.push_back(known_row(OP_LOOKUP, 0, 0, 0, ST_RANGE, 0, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 0, 0, 0, ST_RANGE, 0, 0, 0));
    directed.push_back(cmd_row(OP_RESET, 0, 0, 0));
    directed.push_back(cfg_row(8191));
    directed.push_back(cmd_row(OP_LOOKUP, 4095, 0, 0));
    directed.push_back(cmd_row(OP_UPDATE, 4095, 4095, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      if (directed[k].is_cfg) write_page_limit(directed[k].cfg_value);
      else send_command(directed[k].c, directed[k].known, directed[k].expected);
    end

    for (int phase = 0; phase < 4; phase++) begin
      write_page_limit(PHASE_BOUNDS[phase]);
      send_idle_pct = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 0 && k == 60) hold_kick = 1'b1;
        if (phase == 1 && k == 75) drain_results();
        send_command(random_command(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d commands sent, %0d responses checked across several page bounds",
             commands_sent, results_seen);
    $display("%0d hit a mapping, %0d double invalidations, %0d out of range, %0d mismatches",
             mapped_hits, double_invals, range_errors, mismatches);
    if (mismatches == 0 && translation_results.size() == 0)
      $display("page_map_table_engine_top_tb passed");
    else
      $display("page_map_table_engine_top_tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/pmte_pkg.sv
design/pmte_ram.sv
design/pmte_split.sv
design/page_map_table_engine_top.sv
sim/page_map_table_engine_top_tb.sv
